// ===== rtl/usr_pkg.sv =====
package usr_pkg;

  typedef enum logic [2:0] {
    CMD_BEGIN    = 3'd0,
    CMD_CHUNK    = 3'd1,
    CMD_FINALIZE = 3'd2,
    CMD_ABORT    = 3'd3,
    CMD_STATUS   = 3'd4,
    CMD_REBOOT   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    CODE_OK          = 3'd0,
    CODE_BAD_IMAGE   = 3'd1,
    CODE_BAD_SESSION = 3'd2,
    CODE_BUSY        = 3'd3,
    CODE_BAD_OFFSET  = 3'd4,
    CODE_BAD_CRC     = 3'd5,
    CODE_NOT_READY   = 3'd6,
    CODE_UNSUPPORTED = 3'd7
  } code_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_RECEIVING = 2'd1,
    PH_FAILED    = 2'd2,
    PH_READY     = 2'd3
  } phase_t;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam int unsigned CB_W = 17;

  // request handed from the front part to the back part
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] sess_tag;
    logic [31:0] img_tag;
    logic [31:0] img_len;
    logic [15:0] seg_limit;
    logic [31:0] seg_total;
    logic [31:0] seg_num;
    logic [31:0] byte_offset;
    logic [31:0] chunk_check;
    logic        begin_bad;   // begin field check failed
    logic        chunk_end;   // last byte, carries finished chunk
    logic [31:0] crc;         // finished chunk crc (complemented)
    logic [CB_W-1:0] size;    // finished chunk size
  } req_t;

  // result item
  typedef struct packed {
    logic        kind;
    logic [31:0] ack_session;
    logic [31:0] ack_image;
    logic [31:0] ack_index;
    logic [2:0]  ack_code;
    logic [1:0]  session_state;
    logic [31:0] report_size;
    logic [31:0] report_written;
    logic [31:0] report_offset;
    logic [2:0]  report_error;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== rtl/update_session_receiver_unit.sv =====
// Update session receiver: the receiving end of a chunked image transfer.
// Input channel: queue style, a request is taken on a clock edge with in_push
// high and in_full low. Each request holds one command (begin, chunk byte,
// finalize, abort, status, reboot, unknown) with its header fields.
// Result channel: queue style, the oldest result sits on out_* while out_empty
// is low and leaves on an edge with out_pop high.
// Chunk bytes stream in one per cycle while in_full is low; the front keeps
// a running CRC-32 and byte count and forwards only the last byte of a chunk
// plus every other command. The back holds the session state and forms one
// ack or status report per forwarded request, written into the result queue
// on the same edge; from the next cycle it sits on out_* once older ones leave.
// Throughput: one request per cycle while the result queue has room; the
// queue depth (OUT_DEPTH) bounds how far the sender runs ahead of out_pop.
// When the receiver stalls, the queue fills and in_full rises; nothing is lost.
// Reset (synchronous, rst_n low): session cleared, phase idle, CRC all ones,
// result queue empty.
module update_session_receiver_unit
  import usr_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_BYTES = 256,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_sess_tag,
  input  logic [31:0] in_img_tag,
  input  logic [31:0] in_img_len,
  input  logic [15:0] in_seg_limit,
  input  logic [31:0] in_seg_total,
  input  logic [31:0] in_seg_num,
  input  logic [31:0] in_byte_offset,
  input  logic [31:0] in_chunk_check,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [31:0] out_ack_session,
  output logic [31:0] out_ack_image,
  output logic [31:0] out_ack_index,
  output logic [2:0]  out_ack_code,
  output logic [1:0]  out_session_state,
  output logic [31:0] out_report_size,
  output logic [31:0] out_report_written,
  output logic [31:0] out_report_offset,
  output logic [2:0]  out_report_error
);

  logic take, req_valid, acc_clear, res_valid, q_full, q_rd;
  req_t req;
  res_t res, q_head;

  // one result per request at most; full queue stalls the input
  assign in_full = q_full;
  assign take = in_push && !q_full;
  assign q_rd = out_pop && !out_empty;

  usr_front #(.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_front (
    .clk, .rst_n,
    .in_take(take),
    .in_command, .in_sess_tag, .in_img_tag, .in_img_len, .in_seg_limit,
    .in_seg_total, .in_seg_num, .in_byte_offset, .in_chunk_check,
    .in_data_byte, .in_last_byte,
    .acc_clear,
    .req_valid, .req
  );

  usr_back u_back (
    .clk, .rst_n,
    .req_valid, .req,
    .acc_clear,
    .res_valid, .res
  );

  usr_fifo #(.DEPTH(OUT_DEPTH)) u_fifo (
    .clk, .rst_n,
    .wr(res_valid), .wdata(res),
    .rd(q_rd),
    .empty(out_empty), .full(q_full),
    .rdata(q_head)
  );

  assign out_kind           = q_head.kind;
  assign out_ack_session    = q_head.ack_session;
  assign out_ack_image      = q_head.ack_image;
  assign out_ack_index      = q_head.ack_index;
  assign out_ack_code       = q_head.ack_code;
  assign out_session_state  = q_head.session_state;
  assign out_report_size    = q_head.report_size;
  assign out_report_written = q_head.report_written;
  assign out_report_offset  = q_head.report_offset;
  assign out_report_error   = q_head.report_error;

endmodule

// ===== rtl/usr_front.sv =====
module usr_front
  import usr_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_take,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_sess_tag,
  input  logic [31:0] in_img_tag,
  input  logic [31:0] in_img_len,
  input  logic [15:0] in_seg_limit,
  input  logic [31:0] in_seg_total,
  input  logic [31:0] in_seg_num,
  input  logic [31:0] in_byte_offset,
  input  logic [31:0] in_chunk_check,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // from back part: abort that clears the accumulator
  input  logic        acc_clear,
  output logic        req_valid,
  output req_t        req
);

  logic [31:0]     crc_r, crc_nxt, crc_upd;
  logic [CB_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic            is_chunk, is_begin, bad;

  // abort is decided in the back part in the same cycle it is taken and
  // clears the accumulator here; an abort request is never a chunk byte
  always_comb begin
    is_chunk = (in_command == CMD_CHUNK);
    is_begin = (in_command == CMD_BEGIN);
    bad = (in_sess_tag == '0) || (in_img_tag == '0) || (in_img_len == '0) ||
          (in_seg_limit == '0) || (in_seg_total == '0) ||
          (32'(in_seg_limit) > 32'(MAX_CHUNK_BYTES));
    crc_upd = crc_byte(crc_r, in_data_byte);
    cnt_upd = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (acc_clear) begin
      crc_nxt = '1;
      cnt_nxt = '0;
    end
    if (in_take) begin
      if (is_chunk && !in_last_byte) begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_upd;
      end else if (is_chunk || (is_begin && !bad)) begin
        crc_nxt = '1;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '1;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    req_valid = in_take && !(is_chunk && !in_last_byte);
    req.command      = in_command;
    req.sess_tag     = in_sess_tag;
    req.img_tag      = in_img_tag;
    req.img_len      = in_img_len;
    req.seg_limit    = in_seg_limit;
    req.seg_total    = in_seg_total;
    req.seg_num      = in_seg_num;
    req.byte_offset  = in_byte_offset;
    req.chunk_check  = in_chunk_check;
    req.begin_bad    = bad;
    req.chunk_end    = is_chunk;
    req.crc          = ~crc_upd;
    req.size         = cnt_upd;
  end

endmodule

// ===== rtl/usr_back.sv =====
module usr_back
  import usr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  req_t req,
  output logic acc_clear,
  output logic res_valid,
  output res_t res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] sess_r, sess_nxt, img_r, img_nxt, esize_r, esize_nxt;
  logic [15:0] achunk_r, achunk_nxt;
  logic [31:0] echunks_r, echunks_nxt, written_r, written_nxt;
  logic [31:0] noff_r, noff_nxt, nidx_r, nidx_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        match;
  logic [32:0] end_off;
  code_t       code;
  logic [31:0] idx;

  always_comb begin
    match = (sess_r != '0) && (img_r != '0) &&
            (req.sess_tag == sess_r) && (req.img_tag == img_r);
    end_off = {1'b0, req.byte_offset} + 33'(req.size);
    phase_nxt = phase_r;  sess_nxt = sess_r;  img_nxt = img_r;
    esize_nxt = esize_r;  achunk_nxt = achunk_r; echunks_nxt = echunks_r;
    written_nxt = written_r; noff_nxt = noff_r; nidx_nxt = nidx_r; err_nxt = err_r;
    acc_clear = 1'b0;
    code = CODE_OK;
    idx = nidx_r;
    res = '0;
    res.ack_session = req.sess_tag;
    res.ack_image = req.img_tag;
    if (req_valid) begin
      unique case (req.command)
        CMD_BEGIN: begin
          idx = '0;
          if (req.begin_bad) begin
            code = CODE_BAD_IMAGE;
            err_nxt = CODE_BAD_IMAGE;
            phase_nxt = PH_FAILED;
          end else begin
            phase_nxt = PH_RECEIVING;
            sess_nxt = req.sess_tag; img_nxt = req.img_tag;
            esize_nxt = req.img_len; achunk_nxt = req.seg_limit;
            echunks_nxt = req.seg_total;
            written_nxt = '0; noff_nxt = '0; nidx_nxt = '0; err_nxt = '0;
          end
        end
        CMD_CHUNK: begin
          idx = req.seg_num;
          priority if (!match) code = CODE_BAD_SESSION;
          else if (phase_r != PH_RECEIVING) code = CODE_BUSY;
          else if (req.seg_num != nidx_r || req.byte_offset != noff_r) begin
            code = CODE_BAD_OFFSET; err_nxt = CODE_BAD_OFFSET;
          end else if (req.size > CB_W'(achunk_r) || end_off > {1'b0, esize_r}) begin
            code = CODE_BAD_IMAGE; err_nxt = CODE_BAD_IMAGE;
          end else if (req.crc != req.chunk_check) begin
            code = CODE_BAD_CRC; err_nxt = CODE_BAD_CRC;
          end else begin
            written_nxt = written_r + 32'(req.size);
            noff_nxt = noff_r + 32'(req.size);
            nidx_nxt = nidx_r + 1'b1;
            err_nxt = '0;
          end
        end
        CMD_FINALIZE: begin
          priority if (!match) code = CODE_BAD_SESSION;
          else if (written_r != esize_r || nidx_r != echunks_r) begin
            code = CODE_NOT_READY; err_nxt = CODE_NOT_READY;
          end else begin
            phase_nxt = PH_READY; err_nxt = '0;
          end
        end
        CMD_ABORT: begin
          if (!match) code = CODE_BAD_SESSION;
          else begin
            idx = '0;
            acc_clear = 1'b1;
            phase_nxt = PH_IDLE; sess_nxt = '0; img_nxt = '0; esize_nxt = '0;
            achunk_nxt = '0; echunks_nxt = '0; written_nxt = '0; noff_nxt = '0;
            nidx_nxt = '0; err_nxt = '0;
          end
        end
        CMD_STATUS: ;
        CMD_REBOOT: begin
          priority if (!match) code = CODE_BAD_SESSION;
          else if (phase_r != PH_READY) code = CODE_NOT_READY;
          else code = CODE_UNSUPPORTED;
        end
        default: begin
          code = CODE_UNSUPPORTED;
          res.ack_session = sess_r;
          res.ack_image = img_r;
        end
      endcase
    end
    res.ack_index = idx;
    res.ack_code = code;
    res.session_state = phase_nxt;
    if (req.command == CMD_STATUS) begin
      res.kind = 1'b1;
      res.ack_session = sess_r;
      res.ack_image = img_r;
      res.ack_index = '0;
      res.ack_code = CODE_OK;
      res.report_size = esize_r;
      res.report_written = written_r;
      res.report_offset = noff_r;
      res.report_error = err_r;
    end
    res_valid = req_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; sess_r <= '0; img_r <= '0; esize_r <= '0;
      achunk_r <= '0; echunks_r <= '0; written_r <= '0; noff_r <= '0;
      nidx_r <= '0; err_r <= '0;
    end else begin
      phase_r <= phase_nxt; sess_r <= sess_nxt; img_r <= img_nxt;
      esize_r <= esize_nxt; achunk_r <= achunk_nxt; echunks_r <= echunks_nxt;
      written_r <= written_nxt; noff_r <= noff_nxt; nidx_r <= nidx_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// ===== rtl/usr_fifo.sv =====
module usr_fifo
  import usr_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  res_t wdata,
  input  logic rd,
  output logic empty,
  output logic full,
  output res_t rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  res_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// ===== bench/update_session_receiver_unit_test.sv =====
`timescale 1ns / 100ps

module update_session_receiver_unit_test;
  import usr_pkg::*;

  localparam int unsigned MAX_CHUNK = 256;
  localparam int ITEMS = 1550;
  localparam logic [2:0] CMD_UNKNOWN = 3'd6;
  localparam logic [2:0] CMD_SEVEN = 3'd7;

  // one request as the block sees it
  typedef struct {
    logic [2:0]  command;
    logic [31:0] sess_tag;
    logic [31:0] img_tag;
    logic [31:0] img_len;
    logic [15:0] seg_limit;
    logic [31:0] seg_total;
    logic [31:0] seg_num;
    logic [31:0] byte_offset;
    logic [31:0] chunk_check;
    logic [7:0]  data_byte;
    logic        last_byte;
  } request_t;

  // Shadow of the session state; predicts the ack or status report per request.
  class session_scoreboard;
    phase_t      phase;
    logic [31:0] sess, img, exp_size, exp_chunks, written, nxt_off, nxt_idx;
    logic [15:0] allowed;
    code_t       err;
    logic [31:0] crc;
    logic [16:0] count;
    res_t        pending[$];
    int          mismatches;

    function void clear_session();
      phase = PH_IDLE; sess = 0; img = 0; exp_size = 0; allowed = 0;
      exp_chunks = 0; written = 0; nxt_off = 0; nxt_idx = 0; err = CODE_OK;
    endfunction

    function void clear_chunk();
      crc = 32'hFFFF_FFFF; count = 0;
    endfunction

    function void reset_state();
      clear_session(); clear_chunk(); pending.delete(); mismatches = 0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      repeat (8) x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
      return x;
    endfunction

    function bit matches_session(logic [31:0] s, logic [31:0] im);
      return sess != 0 && img != 0 && s == sess && im == img;
    endfunction

    function void push_ack(logic [31:0] s, logic [31:0] im, logic [31:0] idx, code_t c);
      res_t r;
      r = '0;
      r.ack_session = s; r.ack_image = im; r.ack_index = idx;
      r.ack_code = c; r.session_state = phase;
      pending.push_back(r);
    endfunction

    function void note_request(request_t q);
      res_t        r;
      logic [16:0] sz;
      logic [31:0] fin;
      code_t       c;
      case (q.command)
        CMD_BEGIN: begin
          if (q.sess_tag == 0 || q.img_tag == 0 || q.img_len == 0 ||
              q.seg_limit == 0 || q.seg_total == 0 || q.seg_limit > MAX_CHUNK) begin
            err = CODE_BAD_IMAGE; phase = PH_FAILED;
            push_ack(q.sess_tag, q.img_tag, 32'd0, CODE_BAD_IMAGE);
          end else begin
            clear_session(); clear_chunk();
            phase = PH_RECEIVING; sess = q.sess_tag; img = q.img_tag;
            exp_size = q.img_len; allowed = q.seg_limit; exp_chunks = q.seg_total;
            push_ack(q.sess_tag, q.img_tag, 32'd0, CODE_OK);
          end
        end
        CMD_CHUNK: begin
          crc = crc_step(crc, q.data_byte);
          if (count != 17'h1FFFF) count++;
          if (q.last_byte) begin
            sz = count; fin = ~crc;
            clear_chunk();
            if (!matches_session(q.sess_tag, q.img_tag)) c = CODE_BAD_SESSION;
            else if (phase != PH_RECEIVING) c = CODE_BUSY;
            else if (q.seg_num != nxt_idx || q.byte_offset != nxt_off) begin
              c = CODE_BAD_OFFSET; err = c;
            end else if (sz > allowed ||
                         {1'b0, q.byte_offset} + 33'(sz) > {1'b0, exp_size}) begin
              c = CODE_BAD_IMAGE; err = c;
            end else if (fin != q.chunk_check) begin
              c = CODE_BAD_CRC; err = c;
            end else begin
              written += 32'(sz); nxt_off += 32'(sz); nxt_idx++; err = CODE_OK; c = CODE_OK;
            end
            push_ack(q.sess_tag, q.img_tag, q.seg_num, c);
          end
        end
        CMD_FINALIZE: begin
          if (!matches_session(q.sess_tag, q.img_tag))
            c = CODE_BAD_SESSION;
          else if (written != exp_size || nxt_idx != exp_chunks) begin
            c = CODE_NOT_READY; err = c;
          end else begin
            phase = PH_READY; err = CODE_OK; c = CODE_OK;
          end
          push_ack(q.sess_tag, q.img_tag, nxt_idx, c);
        end
        CMD_ABORT: begin
          if (!matches_session(q.sess_tag, q.img_tag))
            push_ack(q.sess_tag, q.img_tag, nxt_idx, CODE_BAD_SESSION);
          else begin
            clear_session(); clear_chunk();
            push_ack(q.sess_tag, q.img_tag, 32'd0, CODE_OK);
          end
        end
        CMD_STATUS: begin
          r = '0;
          r.kind = 1'b1; r.ack_session = sess; r.ack_image = img;
          r.session_state = phase; r.report_size = exp_size;
          r.report_written = written; r.report_offset = nxt_off; r.report_error = err;
          pending.push_back(r);
        end
        CMD_REBOOT: begin
          if (!matches_session(q.sess_tag, q.img_tag)) c = CODE_BAD_SESSION;
          else if (phase != PH_READY) c = CODE_NOT_READY;
          else c = CODE_UNSUPPORTED;
          push_ack(q.sess_tag, q.img_tag, nxt_idx, c);
        end
        default: push_ack(sess, img, nxt_idx, CODE_UNSUPPORTED);
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  request_t    drive = '{default: '0};
  logic        out_empty;
  logic        out_pop = 1'b0;
  res_t        got;

  update_session_receiver_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_command(drive.command), .in_sess_tag(drive.sess_tag),
    .in_img_tag(drive.img_tag), .in_img_len(drive.img_len),
    .in_seg_limit(drive.seg_limit), .in_seg_total(drive.seg_total),
    .in_seg_num(drive.seg_num), .in_byte_offset(drive.byte_offset),
    .in_chunk_check(drive.chunk_check), .in_data_byte(drive.data_byte),
    .in_last_byte(drive.last_byte),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_kind(got.kind), .out_ack_session(got.ack_session),
    .out_ack_image(got.ack_image), .out_ack_index(got.ack_index),
    .out_ack_code(got.ack_code), .out_session_state(got.session_state),
    .out_report_size(got.report_size), .out_report_written(got.report_written),
    .out_report_offset(got.report_offset), .out_report_error(got.report_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  session_scoreboard board = new();

  // idle percentages, changed per phase of the run
  int send_idle = 36;
  int recv_idle = 54;
  // requests taken so far
  int n_sent = 0;

  // sender-side view of the session, used to build mostly well-formed traffic
  logic [31:0] cur_sess = '0, cur_img = '0, cur_off = '0, cur_idx = '0, cur_size = '0;
  logic [15:0] cur_chunk = '0;

  // Checking at the rising edge; pop is chosen at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(got);
  end

  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= recv_idle);
  end

  // Hand one request to the block; returns at the edge that took it.
  // push stays high so the next request can follow without a gap.
  task automatic send(request_t q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    drive <= q;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    board.note_request(q);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic request_t noise();
    request_t q;
    q.command = 3'($urandom_range(7));
    q.sess_tag = $urandom; q.img_tag = $urandom; q.img_len = $urandom;
    q.seg_limit = 16'($urandom); q.seg_total = $urandom; q.seg_num = $urandom;
    q.byte_offset = $urandom; q.chunk_check = $urandom;
    q.data_byte = 8'($urandom); q.last_byte = 1'($urandom);
    return q;
  endfunction

  // plain request addressed to the current session
  function automatic request_t own(logic [2:0] cmd);
    request_t q;
    q = noise();
    q.command = cmd; q.sess_tag = cur_sess; q.img_tag = cur_img;
    return q;
  endfunction

  task automatic open_session(logic [31:0] size, logic [15:0] csz, logic [31:0] chunks);
    request_t q;
    q = noise();
    cur_sess = $urandom | 1; cur_img = $urandom | 1;
    q.command = CMD_BEGIN; q.sess_tag = cur_sess; q.img_tag = cur_img;
    q.img_len = size; q.seg_limit = csz; q.seg_total = chunks;
    cur_off = 0; cur_idx = 0; cur_size = size; cur_chunk = csz;
    send(q);
  endtask

  // Stream one chunk; flaw picks a deliberate fault (0 = none).
  task automatic send_chunk(int len, int flaw);
    request_t q;
    logic [31:0] c;
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < len; i++) begin
      q = own(CMD_CHUNK);
      q.last_byte = (i == len - 1);
      c = board.crc_step(c, q.data_byte);
      q.seg_num = cur_idx; q.byte_offset = cur_off; q.chunk_check = ~c;
      if (q.last_byte) begin
        case (flaw)
          1: q.chunk_check ^= 32'h1 << $urandom_range(31);
          2: q.seg_num += 1;
          3: q.byte_offset += 1;
          4: q.sess_tag ^= 32'h1;
          default: ;
        endcase
      end
      send(q);
    end
    if (flaw == 0) begin
      cur_off += 32'(len); cur_idx += 1;
    end
  endtask

  // Full transfer: begin, chunks (some flawed), finalize, reboot, sometimes status or abort.
  task automatic transfer();
    int nchunks, len, sz, flaw, rest;
    if (($urandom_range(19) == 0) && (n_sent + 300 < ITEMS)) begin
      nchunks = 1;
      len = MAX_CHUNK;
    end else begin
      nchunks = $urandom_range(1, 5);
      len = $urandom_range(1, 8);
    end
    sz = nchunks * len - int'($urandom_range(len - 1));
    open_session(32'(sz), 16'(len), 32'(nchunks));
    while (int'(cur_off) < sz) begin
      flaw = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : 0;
      rest = sz - int'(cur_off);
      send_chunk((rest < len) ? rest : len, flaw);
      if ($urandom_range(9) == 0) send(own(CMD_STATUS));
    end
    if ($urandom_range(5) == 0) send_chunk(1, 0);   // overrun past the image
    send(own(CMD_FINALIZE));
    send(own(CMD_REBOOT));
    if ($urandom_range(1)) send(own(CMD_STATUS));
    if ($urandom_range(3) == 0) send(own(CMD_ABORT));
  endtask

  initial begin
    request_t q;
    board.reset_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reboot with no session, status at reset,
    // rejected begins (each zero field, oversize chunk), unknown commands.
    send(own(CMD_STATUS));
    send(own(CMD_REBOOT));
    q = noise(); q.command = CMD_BEGIN; q.sess_tag = 0; send(q);
    q = noise(); q.command = CMD_BEGIN; q.img_tag = 0; send(q);
    q = noise(); q.command = CMD_BEGIN; q.img_len = 0; send(q);
    q = noise(); q.command = CMD_BEGIN; q.seg_limit = 0; send(q);
    q = noise(); q.command = CMD_BEGIN; q.seg_total = 0; q.seg_limit = 4; send(q);
    q = noise(); q.command = CMD_BEGIN; q.seg_limit = 16'(MAX_CHUNK + 1);
    q.img_tag |= 1; q.sess_tag |= 1; q.img_len |= 1; q.seg_total |= 1; send(q);
    q = noise(); q.command = CMD_BEGIN; q.seg_limit = 16'hFFFF; send(q);
    q = noise(); q.command = CMD_UNKNOWN; send(q);
    q = noise(); q.command = CMD_SEVEN; send(q);
    // chunk outside any session
    send_chunk(2, 0);
    // accepted begin at extremes, full chunk, busy after finalize
    open_session(32'(MAX_CHUNK), 16'(MAX_CHUNK), 32'd1);
    send_chunk(MAX_CHUNK, 0);
    send(own(CMD_FINALIZE));
    send(own(CMD_REBOOT));
    send_chunk(1, 0);
    send(own(CMD_STATUS));
    // size and chunk count all ones, stray offset, abort with wrong and right ids
    cur_sess = 32'hFFFF_FFFF;
    open_session(32'hFFFF_FFFF, 16'd1, 32'hFFFF_FFFF);
    q = own(CMD_CHUNK); q.last_byte = 1; q.byte_offset = 32'hFFFF_FFFF; send(q);
    q = own(CMD_ABORT); q.img_tag ^= 1; send(q);
    send(own(CMD_ABORT));
    send(own(CMD_STATUS));

    // Random traffic: three idle profiles, a pause until drained in between.
    for (int stage = 0; stage < 3; stage++) begin
      send_idle = (stage == 0) ? 36 : (stage == 1) ? 54 : 0;
      recv_idle = (stage == 0) ? 54 : (stage == 1) ? 36 : 0;
      while (n_sent < (stage + 1) * ITEMS / 3) begin
        if ($urandom_range(9) < 7) transfer();
        else send(noise());
      end
      wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("update_session_receiver_unit verification clean");
    else
      $display("update_session_receiver_unit verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("update_session_receiver_unit verification failed");
    $finish;
  end

endmodule
